>>> rtl/pulse_period_to_soil_suction_core_defines.svh
// Assertion macros shared by the checker of the suction core.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef PULSE_PERIOD_TO_SOIL_SUCTION_CORE_DEFINES_SVH
`define PULSE_PERIOD_TO_SOIL_SUCTION_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define PPSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define PPSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ppss_pkg.sv
// Package for the pulse period to soil suction core: segment tables,
// fixed constants and the command and status bundles. Depends on nothing.
package ppss_pkg;

    // Microseconds per second, numerator of the frequency division.
    localparam int unsigned US_PER_S = 1000000;
    // Fraction bits of the segment slopes.
    localparam int SLOPE_BITS = 20;
    // Below this frequency the suction saturates at its maximum.
    localparam int unsigned FLOOR_HZ = 293;
    localparam int unsigned MAX_KPA = 200;

    localparam int SEG_COUNT = 7;
    localparam int SEG_IDX_W = 3;

    // Configuration register address bits above the byte lane bits.
    localparam logic REG_SAMPLES_PER_READING = 1'b0;

    // Segment i applies for upper[i-1] < f <= upper[i].
    localparam logic [12:0] SEG_UPPER_HZ [SEG_COUNT] =
        '{13'd485, 13'd600, 13'd770, 13'd1110, 13'd2820, 13'd4330, 13'd6430};
    localparam logic [7:0] SEG_BASE_KPA [SEG_COUNT] =
        '{8'd200, 8'd100, 8'd75, 8'd55, 8'd35, 8'd15, 8'd9};
    // The top segment keeps its offset of 4600 rather than its lower edge.
    localparam logic [12:0] SEG_OFFSET_HZ [SEG_COUNT] =
        '{13'd293, 13'd485, 13'd600, 13'd770, 13'd1110, 13'd2820, 13'd4600};
    localparam logic [19:0] SEG_SLOPE_Q20 [SEG_COUNT] =
        '{20'd546098, 20'd227960, 20'd123313, 20'd61698, 20'd12268, 20'd4167, 20'd4494};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture an input beat
        logic div_start;  // start the divider
        logic div_mean;   // divider operands: mean (1) or frequency (0)
        logic accum;      // add the frequency quotient to the sum
        logic take_mean;  // capture the mean and clear the accumulator
        logic map_sel;    // pick the table segment
        logic map_mul;    // multiply offset by slope
        logic map_out;    // finish the suction and load the output register
    } ppss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;   // divider quotient is final
        logic complete;   // this sample completes a reading
        logic out_busy;   // output register holds an untaken beat
    } ppss_sts_t;

endpackage

>>> rtl/ppss_divider.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on nothing; used by ppss_datapath.
module ppss_divider #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 21
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One shift-and-subtract step on the partial remainder.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/ppss_datapath.sv
// Datapath of the suction core: period, divider, accumulator, segment
// mapping and output register. Depends on ppss_pkg and ppss_divider.
module ppss_datapath #(
    parameter int PERIOD_WIDTH   = 21,
    parameter int FREQ_FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ppss_pkg::ppss_cmd_t cmd,
    output ppss_pkg::ppss_sts_t sts,
    input  logic [19:0]         high_time_us,
    input  logic [19:0]         low_time_us,
    input  logic [2:0]          sensor_channel,
    input  logic [3:0]          samples_per_reading,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          suction_kpa,
    output logic [19:0]         mean_frequency_hz,
    output logic [2:0]          reading_channel
);

    localparam int DIV_W = (PERIOD_WIDTH > 20) ? PERIOD_WIDTH : 20;
    localparam int SH    = FREQ_FRAC_BITS + ppss_pkg::SLOPE_BITS;
    localparam int D_W   = FREQ_FRAC_BITS + 12;
    localparam int P_W   = D_W + ppss_pkg::SLOPE_BITS + 1;
    localparam int VAL_W = P_W + 1;
    localparam int KPA_W = VAL_W - SH;
    localparam logic [31:0] FREQ_NUM = 32'(64'(ppss_pkg::US_PER_S) << FREQ_FRAC_BITS);

    logic [DIV_W-1:0]               period_reg, period_next;
    logic [2:0]                     chan_reg;
    logic [31:0]                    sum_reg, sum_next;
    logic [3:0]                     samples_reg, samples_next;
    logic [31:0]                    mean_reg;
    logic [32:0]                    period_sum;
    logic [PERIOD_WIDTH-1:0]        period_masked;
    logic [4:0]                     count;
    logic [4:0]                     needed;
    logic                           complete;
    logic [31:0]                    div_dividend;
    logic [DIV_W-1:0]               div_divisor;
    logic                           div_done;
    logic [31:0]                    div_quotient;
    logic                           below;
    logic                           found;
    logic [ppss_pkg::SEG_IDX_W-1:0] idx;
    logic signed [33:0]             diff;
    logic [ppss_pkg::SEG_IDX_W-1:0] idx_reg;
    logic                           below_reg;
    logic                           found_reg;
    logic signed [D_W-1:0]          d_reg;
    logic signed [P_W-1:0]          prod_reg;
    logic signed [VAL_W-1:0]        base_sh;
    logic signed [VAL_W-1:0]        val;
    logic [KPA_W-1:0]               kpa_wide;
    logic [7:0]                     kpa_next;
    logic                           out_valid_reg;
    logic [7:0]                     suction_reg;
    logic [19:0]                    mean_hz_reg;
    logic [2:0]                     out_chan_reg;

    // Period of the input beat; an empty period counts as one second.
    always_comb
    begin
        period_sum    = 33'(high_time_us) + 33'(low_time_us);
        period_masked = period_sum[PERIOD_WIDTH-1:0];
        period_next   = (period_masked == '0) ? DIV_W'(ppss_pkg::US_PER_S)
                                              : DIV_W'(period_masked);
    end

    // Sample count against the configured reading length; zero acts as one.
    always_comb
    begin
        count    = {1'b0, samples_reg} + 5'd1;
        needed   = (samples_per_reading == 4'd0) ? 5'd1 : {1'b0, samples_per_reading};
        complete = count >= needed;
    end

    // Shared divider: frequency from the period, or mean from the sum.
    assign div_dividend = cmd.div_mean ? sum_reg : FREQ_NUM;
    assign div_divisor  = cmd.div_mean ? DIV_W'(count) : period_reg;

    ppss_divider #(
        .DIVIDEND_W (32),
        .DIVISOR_W  (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Accumulator update; it clears once the mean has been taken.
    always_comb
    begin
        sum_next     = sum_reg;
        samples_next = samples_reg;
        if (cmd.take_mean)
        begin
            sum_next     = '0;
            samples_next = '0;
        end
        else if (cmd.accum)
        begin
            sum_next = sum_reg + div_quotient;
            if (!complete)
            begin
                samples_next = count[3:0];
            end
        end
    end

    // Segment search over the table bounds, first match wins.
    always_comb
    begin
        below = mean_reg < (32'(ppss_pkg::FLOOR_HZ) << FREQ_FRAC_BITS);
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < ppss_pkg::SEG_COUNT; i++)
        begin
            if (!found && mean_reg <= (32'(ppss_pkg::SEG_UPPER_HZ[i]) << FREQ_FRAC_BITS))
            begin
                found = 1'b1;
                idx   = ppss_pkg::SEG_IDX_W'(i);
            end
        end
        diff = $signed({2'b00, mean_reg})
             - $signed(34'(ppss_pkg::SEG_OFFSET_HZ[idx]) << FREQ_FRAC_BITS);
    end

    // Suction from base, offset product and clamps, truncated toward zero.
    always_comb
    begin
        base_sh  = $signed(VAL_W'(ppss_pkg::SEG_BASE_KPA[idx_reg]) << SH);
        val      = base_sh - VAL_W'(prod_reg);
        kpa_wide = val[VAL_W-1:SH];
        if (below_reg)
        begin
            kpa_next = 8'(ppss_pkg::MAX_KPA);
        end
        else if (!found_reg || val[VAL_W-1] || val == '0)
        begin
            kpa_next = '0;
        end
        else if (kpa_wide > KPA_W'(ppss_pkg::MAX_KPA))
        begin
            kpa_next = 8'(ppss_pkg::MAX_KPA);
        end
        else
        begin
            kpa_next = kpa_wide[7:0];
        end
    end

    // Control state: accumulator, sample count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            samples_reg <= samples_next;
            if (cmd.map_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers along the pipeline of one reading.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            period_reg <= period_next;
            chan_reg   <= sensor_channel;
        end
        if (cmd.take_mean)
        begin
            mean_reg <= div_quotient;
        end
        if (cmd.map_sel)
        begin
            idx_reg   <= idx;
            below_reg <= below;
            found_reg <= found;
            d_reg     <= diff[D_W-1:0];
        end
        if (cmd.map_mul)
        begin
            prod_reg <= d_reg * $signed({1'b0, ppss_pkg::SEG_SLOPE_Q20[idx_reg]});
        end
        if (cmd.map_out)
        begin
            suction_reg  <= kpa_next;
            mean_hz_reg  <= mean_reg[FREQ_FRAC_BITS+19:FREQ_FRAC_BITS];
            out_chan_reg <= chan_reg;
        end
    end

    assign sts.div_done      = div_done;
    assign sts.complete      = complete;
    assign sts.out_busy      = out_valid_reg && !out_ready;
    assign out_valid         = out_valid_reg;
    assign suction_kpa       = suction_reg;
    assign mean_frequency_hz = mean_hz_reg;
    assign reading_channel   = out_chan_reg;

endmodule

>>> rtl/ppss_ctrl.sv
// Controller of the suction core: sequences divisions, accumulation and
// the segment mapping for one beat at a time. Depends on ppss_pkg.
module ppss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppss_pkg::ppss_sts_t sts,
    output ppss_pkg::ppss_cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START_F = 3'd1;
    localparam logic [2:0] S_WAIT_F  = 3'd2;
    localparam logic [2:0] S_START_M = 3'd3;
    localparam logic [2:0] S_WAIT_M  = 3'd4;
    localparam logic [2:0] S_SEL     = 3'd5;
    localparam logic [2:0] S_MUL     = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0] state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START_F;
                end
            end
            S_START_F:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_F;
            end
            S_WAIT_F:
            begin
                if (sts.div_done)
                begin
                    cmd.accum  = 1'b1;
                    state_next = sts.complete ? S_START_M : S_IDLE;
                end
            end
            S_START_M:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
                state_next    = S_WAIT_M;
            end
            S_WAIT_M:
            begin
                if (sts.div_done)
                begin
                    cmd.take_mean = 1'b1;
                    state_next    = S_SEL;
                end
            end
            S_SEL:
            begin
                cmd.map_sel = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.map_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

>>> rtl/pulse_period_to_soil_suction_core.sv
// Top level of the pulse period to soil suction core.
// Depends on ppss_pkg, ppss_ctrl and ppss_datapath.
//
// Each input beat carries one oscillator cycle (high and low time in us);
// its frequency 1e6/period in fixed point is summed, and after
// samples_per_reading beats the mean frequency is mapped through a
// seven-segment table to suction in kPa and sent as one output beat. One
// beat at a time is processed. A beat that does not finish a reading holds
// the input closed from its acceptance until the 32-step bit-serial divider
// has produced its frequency. The beat that finishes a reading runs that
// divider a second time for the mean and then three mapping steps, the
// last of which waits while the output register holds an untaken beat,
// before the next beat can be taken.
// A finished reading waits in an output register, so the next beat is taken
// while it is held; only the following reading waits for it to be taken.
// Register samples_per_reading sits at byte address 0 and resets to 10.
module pulse_period_to_soil_suction_core #(
    parameter int PERIOD_WIDTH   = 21,
    parameter int FREQ_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [19:0] high_time_us, [39:20] low_time_us
    input  logic [2:0]  s_tuser,   // [2:0] sensor_channel
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] suction_kpa, [27:8] mean_frequency_hz, [31:28] zero
    output logic [2:0]  m_tuser,   // [2:0] reading_channel
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ppss_pkg::ppss_cmd_t cmd;
    ppss_pkg::ppss_sts_t sts;
    logic [3:0]          samples_cfg_reg;
    logic                cfg_hit;
    logic [7:0]          suction_kpa;
    logic [19:0]         mean_frequency_hz;

    // Configuration register, written in the access phase.
    assign cfg_hit = paddr[2] == ppss_pkg::REG_SAMPLES_PER_READING;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_cfg_reg <= 4'd10;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            samples_cfg_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_hit ? {28'd0, samples_cfg_reg} : 32'd0;

    ppss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppss_datapath #(
        .PERIOD_WIDTH   (PERIOD_WIDTH),
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .high_time_us        (s_tdata[19:0]),
        .low_time_us         (s_tdata[39:20]),
        .sensor_channel      (s_tuser),
        .samples_per_reading (samples_cfg_reg),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .suction_kpa         (suction_kpa),
        .mean_frequency_hz   (mean_frequency_hz),
        .reading_channel     (m_tuser)
    );

    // Output beat packing.
    assign m_tdata = {4'd0, mean_frequency_hz, suction_kpa};

endmodule

>>> rtl/ppss_checker.sv
// Port-level checker for the suction core, bound to the top level.
// Depends on pulse_period_to_soil_suction_core_defines.svh.
`include "pulse_period_to_soil_suction_core_defines.svh"

module ppss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled output beat holds its payload.
    `PPSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

    // Suction never exceeds its full scale.
    `PPSS_ASSERT_NOW(a_kpa_range, m_tvalid, m_tdata[7:0] <= 8'd200, "suction above 200 kPa")

    // Padding bits of the output beat stay zero.
    `PPSS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[31:28] == 4'd0, "output padding not zero")

    // An accepted beat keeps the input closed for at least the next cycle.
    `PPSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input ready right after a beat")

endmodule

bind pulse_period_to_soil_suction_core ppss_checker u_ppss_checker (.*);
